@@ src/upc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART period command parser package
// Shared constants, character codes, status codes and control types.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam int CMD_CAPACITY_DEF = 10;
    localparam int PERIOD_W         = 14;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 14'd1000;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SOF   = 8'h24;
    localparam logic [7:0] CH_EOF   = 8'h26;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_O_UP  = 8'h4F;
    localparam logic [7:0] CH_O_LO  = 8'h6F;
    localparam logic [7:0] CH_I_UP  = 8'h49;
    localparam logic [7:0] CH_I_LO  = 8'h69;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Frame layout, as offsets from the start mark.
    localparam int TYPE_OFF        = 1;
    localparam int TARGET_OFF      = 2;
    localparam int FIRST_DIGIT_OFF = 3;
    localparam int LAST_DIGIT_OFF  = 6;
    localparam int END_MARK_OFF    = 7;
    localparam int MIN_FRAME_LEN   = 8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BUF_FULL   = 2'd1,
        ST_BAD_FORMAT = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic store_char;
        logic scan_start;
        logic scan_step;
        logic eval_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic rx_is_cr;
        logic scan_done;
    } t_dp_sts;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ src/upc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART period command parser controller
// Sequences character transfers, the frame scan and the result register.
// ----------------------------------------------------------------------------
module upc_ctrl
    import upc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_out_free;
    logic    w_stall;
    logic    w_accept;
    t_dp_cmd w_cmd;

    // The result register may be reloaded when it is empty or is being taken.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !w_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_sts.rx_is_cr) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.scan_start = i_sts.rx_is_cr;
                    w_cmd.store_char = !i_sts.rx_is_cr;
                end
            end
            S_SCAN: w_cmd.scan_step = 1'b1;
            S_EVAL: w_cmd.eval_commit = w_out_free;
            default: w_cmd = '0;
        endcase
    end

    always_comb begin
        if (w_cmd.store_char || w_cmd.eval_commit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = w_stall;
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

`ifndef ASSERT_OFF
    a_cr_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.rx_is_cr) |=> (r_state == S_SCAN))
        else $error("accepted carriage return did not start a scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(w_cmd.store_char || w_cmd.eval_commit))
        else $error("result register reloaded while its transfer is stalled");

    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.eval_commit |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("frame evaluation did not produce a result");
`endif

endmodule

@@ src/upc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART period command parser datapath
// Character store, frame scan flags, decimal accumulator and period registers.
// ----------------------------------------------------------------------------
module upc_datapath
    import upc_pkg::*;
#(
    parameter int CMD_CAPACITY = CMD_CAPACITY_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_char,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [1:0]          o_status,
    output logic                o_processed,
    output logic [PERIOD_W-1:0] o_pwm_period_ms,
    output logic [PERIOD_W-1:0] o_input_period_ms
);

    localparam int CNT_W = $clog2(CMD_CAPACITY + 1);
    localparam int IDX_W = $clog2(CMD_CAPACITY);

    logic [7:0] r_mem [CMD_CAPACITY];

    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_idx;
    logic [7:0]          r_q;
    logic                r_q_vld;
    logic                r_has_sof;
    logic                r_has_eof;
    logic                r_extra_sof;
    logic                r_nondigit;
    logic [CNT_W-1:0]    r_off;
    logic [CNT_W-1:0]    r_eof_off;
    logic [7:0]          r_type;
    logic [7:0]          r_target;
    logic [PERIOD_W-1:0] r_val;
    logic [PERIOD_W-1:0] r_pwm_period;
    logic [PERIOD_W-1:0] r_input_period;
    t_status             r_status;
    logic                r_processed;

    logic             w_room;
    logic             w_rd_ok;
    logic [CNT_W-1:0] w_cur;
    t_status          w_eval_status;
    logic             w_load_pwm;
    logic             w_load_input;
    logic             w_is_o;
    logic             w_is_i;

    assign w_room  = r_fill < CNT_W'(CMD_CAPACITY);
    assign w_rd_ok = r_idx < r_fill;
    assign w_cur   = r_off + CNT_W'(1);

    assign o_sts.rx_is_cr  = (i_rx_char == CH_CR);
    assign o_sts.scan_done = (r_idx == r_fill) && !r_q_vld;

    // Character store with a registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_char && w_room) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_rx_char;
        end
        if (i_cmd.scan_step && w_rd_ok) begin
            r_q <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.eval_commit) begin
            r_fill <= '0;
        end else if (i_cmd.store_char && w_room) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // One stored character per cycle. Offsets count from the first start mark;
    // everything after the first end mark is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_q_vld     <= 1'b0;
            r_has_sof   <= 1'b0;
            r_has_eof   <= 1'b0;
            r_extra_sof <= 1'b0;
            r_nondigit  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx       <= '0;
            r_q_vld     <= 1'b0;
            r_has_sof   <= 1'b0;
            r_has_eof   <= 1'b0;
            r_extra_sof <= 1'b0;
            r_nondigit  <= 1'b0;
            r_val       <= '0;
        end else if (i_cmd.scan_step) begin
            r_q_vld <= w_rd_ok;
            if (w_rd_ok) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_q_vld && !r_has_eof) begin
                if (r_has_sof) begin
                    r_off <= w_cur;
                    if (w_cur == CNT_W'(TYPE_OFF)) begin
                        r_type <= r_q;
                    end
                    if (w_cur == CNT_W'(TARGET_OFF)) begin
                        r_target <= r_q;
                    end
                    if (r_q == CH_EOF) begin
                        r_has_eof <= 1'b1;
                        r_eof_off <= w_cur;
                    end else begin
                        if (r_q == CH_SOF) begin
                            r_extra_sof <= 1'b1;
                        end
                        if (w_cur >= CNT_W'(FIRST_DIGIT_OFF) && !is_digit(r_q)) begin
                            r_nondigit <= 1'b1;
                        end
                        if (w_cur >= CNT_W'(FIRST_DIGIT_OFF)
                                && w_cur <= CNT_W'(LAST_DIGIT_OFF)) begin
                            r_val <= (r_val << 3) + (r_val << 1) + PERIOD_W'(r_q[3:0]);
                        end
                    end
                end else if (r_q == CH_SOF) begin
                    r_has_sof <= 1'b1;
                    r_off     <= '0;
                end else if (r_q == CH_EOF) begin
                    // An end mark with no start mark before it fails the frame.
                    r_has_eof <= 1'b1;
                end
            end
        end
    end

    assign w_is_o = (r_target == CH_O_UP) || (r_target == CH_O_LO);
    assign w_is_i = (r_target == CH_I_UP) || (r_target == CH_I_LO);

    always_comb begin
        w_eval_status = ST_OK;
        w_load_pwm    = 1'b0;
        w_load_input  = 1'b0;
        priority if (!r_has_sof || !r_has_eof) begin
            w_eval_status = ST_BAD_FORMAT;
        end else if (r_extra_sof) begin
            w_eval_status = ST_BAD_FORMAT;
        end else if (r_type != CH_T_UP && r_type != CH_T_LO) begin
            w_eval_status = ST_NOT_FOUND;
        end else if (r_fill < CNT_W'(MIN_FRAME_LEN)) begin
            w_eval_status = ST_BAD_FORMAT;
        end else if (r_nondigit) begin
            w_eval_status = ST_NOT_FOUND;
        end else if (w_is_o || w_is_i) begin
            if (r_eof_off != CNT_W'(END_MARK_OFF)) begin
                w_eval_status = ST_NOT_FOUND;
            end else begin
                w_load_pwm   = w_is_o;
                w_load_input = w_is_i;
            end
        end else begin
            // Unknown target letter: accepted, nothing changes.
            w_eval_status = ST_OK;
        end
    end

    // The periods change only when a new result is loaded, so they can drive
    // the result fields directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= PERIOD_RESET;
            r_input_period <= PERIOD_RESET;
        end else if (i_cmd.eval_commit) begin
            if (w_load_pwm) begin
                r_pwm_period <= r_val;
            end
            if (w_load_input) begin
                r_input_period <= r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_commit) begin
            r_status    <= w_eval_status;
            r_processed <= 1'b1;
        end else if (i_cmd.store_char) begin
            r_status    <= w_room ? ST_OK : ST_BUF_FULL;
            r_processed <= 1'b0;
        end
    end

    assign o_status          = r_status;
    assign o_processed       = r_processed;
    assign o_pwm_period_ms   = r_pwm_period;
    assign o_input_period_ms = r_input_period;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CNT_W'(CMD_CAPACITY)) && (r_idx <= CNT_W'(CMD_CAPACITY)))
        else $error("fill count or scan index out of range");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval_commit |=> (r_fill == '0))
        else $error("store not cleared after frame evaluation");
`endif

endmodule

@@ src/uart_period_command_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART period command parser
// Collects received characters and evaluates "$T<X><4 digits>&" frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall, i_rx_char) carries one received byte
//   per transfer. Output channel (o_valid / i_stall) returns exactly one
//   result per input byte: status, processed flag and both current periods.
//   A normal byte is stored (status ok) or dropped (status buffer full) and
//   its result is valid in the cycle after the transfer; normal bytes can
//   follow each other every cycle while the receiver does not stall.
//   A carriage return starts a scan of the store, one character per cycle
//   through the store's read port; the frame is then evaluated and its
//   result loaded into the result register, and the next byte is held off
//   until then. The store is emptied afterwards.
//   Reset sets both periods to 1000 ms and empties the store; no result is
//   pending after reset.
//   While the receiver stalls a result, o_stall holds off new bytes, but a
//   scan already started runs to its end and waits for the result register.
// ----------------------------------------------------------------------------
module uart_period_command_parser
    import upc_pkg::*;
#(
    parameter int CMD_CAPACITY = CMD_CAPACITY_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_rx_char,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic                o_processed,
    output logic [PERIOD_W-1:0] o_pwm_period_ms,
    output logic [PERIOD_W-1:0] o_input_period_ms
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    upc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    upc_datapath #(
        .CMD_CAPACITY (CMD_CAPACITY)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_char         (i_rx_char),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_status          (o_status),
        .o_processed       (o_processed),
        .o_pwm_period_ms   (o_pwm_period_ms),
        .o_input_period_ms (o_input_period_ms)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART period command parser testbench
// Sends received characters through the valid/stall input channel and checks
// every result against a cycle-free model of the frame parser kept in the
// bench. A short table of hand-picked characters comes first. Random command
// lines follow: mostly well-formed frames with random content, and the rest
// corrupted frames, overflowing lines and raw noise. The sender works in
// bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
    import upc_pkg::*;

    localparam int CAPACITY     = CMD_CAPACITY_DEF;
    localparam int RANDOM_CHARS = 1100;
    localparam int DRAIN_EVERY  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_status             status;
        logic                processed;
        logic [PERIOD_W-1:0] pwm_ms;
        logic [PERIOD_W-1:0] input_ms;
    } t_period_result;

    typedef struct packed {
        logic [7:0]     ch;
        logic           typed;
        t_period_result want;
    } t_char_row;

    localparam t_period_result FROM_MODEL = '0;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [7:0]          i_rx_char = 8'h00;
    logic                i_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [1:0]          o_status;
    logic                o_processed;
    logic [PERIOD_W-1:0] o_pwm_period_ms;
    logic [PERIOD_W-1:0] o_input_period_ms;

    // Typed expectation that travels with the character being offered.
    logic           cur_typed = 1'b0;
    t_period_result cur_want  = '0;

    // Parser state as the bench sees it.
    logic [7:0]          line_buf [CAPACITY];
    int                  line_len;
    logic [PERIOD_W-1:0] pwm_ms;
    logic [PERIOD_W-1:0] input_ms;

    t_period_result pending_results [$];
    logic [7:0]     line_chars [$];
    int             fail_count  = 0;
    int             cycle_count = 0;
    int             burst_left  = 0;
    int             stall_mode  = 0;
    int             stall_phase = 0;

    t_char_row directed_rows [27] = '{
        '{CH_SOF,  1'b1, '{ST_OK, 1'b0, 14'd1000, 14'd1000}},
        '{CH_T_UP, 1'b0, FROM_MODEL},
        '{CH_O_UP, 1'b0, FROM_MODEL},
        '{CH_NINE, 1'b0, FROM_MODEL},
        '{CH_NINE, 1'b0, FROM_MODEL},
        '{CH_NINE, 1'b0, FROM_MODEL},
        '{CH_NINE, 1'b0, FROM_MODEL},
        '{CH_EOF,  1'b0, FROM_MODEL},
        '{CH_CR,   1'b1, '{ST_OK, 1'b1, 14'd9999, 14'd1000}},
        '{CH_SOF,  1'b0, FROM_MODEL},
        '{CH_T_LO, 1'b0, FROM_MODEL},
        '{CH_I_LO, 1'b0, FROM_MODEL},
        '{CH_ZERO, 1'b0, FROM_MODEL},
        '{CH_ZERO, 1'b0, FROM_MODEL},
        '{CH_ZERO, 1'b0, FROM_MODEL},
        '{CH_ZERO, 1'b0, FROM_MODEL},
        '{CH_EOF,  1'b0, FROM_MODEL},
        '{CH_CR,   1'b1, '{ST_OK, 1'b1, 14'd9999, 14'd0}},
        // Carriage return on an empty line.
        '{CH_CR,   1'b1, '{ST_BAD_FORMAT, 1'b1, 14'd9999, 14'd0}},
        // End mark ahead of the start mark.
        '{8'h00,   1'b0, FROM_MODEL},
        '{CH_EOF,  1'b0, FROM_MODEL},
        '{CH_SOF,  1'b0, FROM_MODEL},
        '{CH_CR,   1'b1, '{ST_BAD_FORMAT, 1'b1, 14'd9999, 14'd0}},
        // Wrong type letter right after the start mark.
        '{CH_SOF,  1'b0, FROM_MODEL},
        '{8'hFF,   1'b0, FROM_MODEL},
        '{CH_EOF,  1'b0, FROM_MODEL},
        '{CH_CR,   1'b1, '{ST_NOT_FOUND, 1'b1, 14'd9999, 14'd0}}
    };

    uart_period_command_parser #(
        .CMD_CAPACITY(CAPACITY)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_char        (i_rx_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_processed      (o_processed),
        .o_pwm_period_ms  (o_pwm_period_ms),
        .o_input_period_ms(o_input_period_ms)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame evaluation on a carriage return.
    // ------------------------------------------------------------------
    function automatic t_status check_frame();
        int          sof;
        int          eof;
        int          k;
        logic        has_sof;
        logic        has_eof;
        logic [7:0]  target;
        int unsigned value;

        sof     = 0;
        eof     = 0;
        has_sof = 1'b0;
        has_eof = 1'b0;
        for (k = 0; k < line_len; k++) begin
            if (!has_sof && line_buf[k] == CH_SOF) begin
                sof     = k;
                has_sof = 1'b1;
            end
            if (!has_eof && line_buf[k] == CH_EOF) begin
                eof     = k;
                has_eof = 1'b1;
            end
        end
        if (!has_sof || !has_eof || eof < sof)
            return ST_BAD_FORMAT;
        for (k = sof + 1; k < eof; k++)
            if (line_buf[k] == CH_SOF)
                return ST_BAD_FORMAT;
        if (line_buf[sof + TYPE_OFF] != CH_T_UP && line_buf[sof + TYPE_OFF] != CH_T_LO)
            return ST_NOT_FOUND;
        if (line_len < MIN_FRAME_LEN)
            return ST_BAD_FORMAT;
        for (k = sof + FIRST_DIGIT_OFF; k < eof; k++)
            if (line_buf[k] < CH_ZERO || line_buf[k] > CH_NINE)
                return ST_NOT_FOUND;

        // The type letter cannot be the end mark, so the target is at or before the end mark.
        target = line_buf[sof + TARGET_OFF];
        if (target == CH_O_UP || target == CH_O_LO
                || target == CH_I_UP || target == CH_I_LO) begin
            if (eof != sof + END_MARK_OFF)
                return ST_NOT_FOUND;
            value = 0;
            for (k = sof + FIRST_DIGIT_OFF; k <= sof + LAST_DIGIT_OFF; k++)
                value = value * 10 + (line_buf[k] - CH_ZERO);
            if (target == CH_O_UP || target == CH_O_LO)
                pwm_ms = value[PERIOD_W-1:0];
            else
                input_ms = value[PERIOD_W-1:0];
        end
        return ST_OK;
    endfunction

    function automatic t_period_result take_char(input logic [7:0] c);
        t_period_result r;

        r.processed = 1'b0;
        if (c == CH_CR) begin
            r.status    = check_frame();
            r.processed = 1'b1;
            line_len    = 0;
        end else if (line_len < CAPACITY) begin
            line_buf[line_len] = c;
            line_len++;
            r.status = ST_OK;
        end else begin
            r.status = ST_BUF_FULL;
        end
        r.pwm_ms   = pwm_ms;
        r.input_ms = input_ms;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random command lines.
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_char();
        logic [7:0] c;

        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_mixed();
        case ($urandom_range(0, 4))
            0: return CH_SOF;
            1: return CH_EOF;
            2: return CH_T_UP;
            3: return rand_digit();
            default: return rand_char();
        endcase
    endfunction

    task automatic build_line();
        int         kind;
        logic [7:0] target;

        line_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            if (kind < 60 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) line_chars.push_back(rand_char());
            line_chars.push_back(CH_SOF);
            if ($urandom_range(0, 9) == 0)
                line_chars.push_back(rand_char());
            else
                line_chars.push_back($urandom_range(0, 1) ? CH_T_UP : CH_T_LO);
            case ($urandom_range(0, 4))
                0: target = CH_O_UP;
                1: target = CH_O_LO;
                2: target = CH_I_UP;
                3: target = CH_I_LO;
                default: target = rand_char();
            endcase
            line_chars.push_back(target);
            repeat (4) line_chars.push_back(rand_digit());
            line_chars.push_back(CH_EOF);
            if (kind < 60) begin
                if ($urandom_range(0, 9) < 3) begin
                    case ($urandom_range(0, 4))
                        0: line_chars.delete(line_chars.size() - 2);
                        1: line_chars.insert(line_chars.size() - 1, rand_digit());
                        2: line_chars.insert($urandom_range(0, line_chars.size()), CH_SOF);
                        3: line_chars[$urandom_range(0, line_chars.size() - 1)] = rand_char();
                        default: line_chars.delete(line_chars.size() - 1);
                    endcase
                end
            end else begin
                // Trailing junk can run past the store, so some characters may get dropped.
                repeat ($urandom_range(2, 5)) line_chars.push_back(rand_char());
            end
            line_chars.push_back(CH_CR);
        end else if (kind < 90) begin
            repeat ($urandom_range(0, 9)) line_chars.push_back(rand_mixed());
            line_chars.push_back(CH_CR);
        end else begin
            repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of transfers separated by random gaps.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic typed,
                             input t_period_result want);
        int gap;

        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_char <= c;
        cur_typed <= typed;
        cur_want  <= want;
        do
            @(posedge i_clk);
        while (o_stall);
        burst_left--;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input transfers feed the model; output transfers are checked.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_period_result predicted;
        t_period_result got;
        t_period_result want;

        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predicted = take_char(i_rx_char);
                pending_results.push_back(cur_typed ? cur_want : predicted);
            end
            if (o_valid && !i_stall) begin
                got.status    = t_status'(o_status);
                got.processed = o_processed;
                got.pwm_ms    = o_pwm_period_ms;
                got.input_ms  = o_input_period_ms;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d processed %0d pwm %0d input %0d",
                                 got.status, got.processed, got.pwm_ms, got.input_ms);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $write("mismatch: status %0d/%0d processed %0d/%0d ",
                                   want.status, got.status, want.processed, got.processed);
                            $display("pwm %0d/%0d input %0d/%0d (expected/actual)",
                                     want.pwm_ms, got.pwm_ms, want.input_ms, got.input_ms);
                        end
                    end
                end
            end
        end
    end

    // Receiver stall pattern: quiet, random and heavy stretches.
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(50, 300);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int sent;
        int next_drain;

        line_len   = 0;
        pwm_ms     = PERIOD_RESET;
        input_ms   = PERIOD_RESET;
        sent       = 0;
        next_drain = DRAIN_EVERY;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_char(directed_rows[k].ch, directed_rows[k].typed, directed_rows[k].want);
        wait_idle();

        while (sent < RANDOM_CHARS) begin
            build_line();
            foreach (line_chars[k])
                send_char(line_chars[k], 1'b0, FROM_MODEL);
            sent += line_chars.size();
            // Let the parser run dry now and then before the next line.
            if (sent >= next_drain) begin
                wait_idle();
                next_drain += DRAIN_EVERY;
            end
        end
        wait_idle();
        repeat (CAPACITY + 10) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
src/upc_pkg.sv
src/upc_ctrl.sv
src/upc_datapath.sv
src/uart_period_command_parser.sv
dv/tb.sv
